// ===== src/analog_threshold_uart_echo_assert.svh =====
// Assertion macros used by the checker of the analog threshold UART echo block.
`ifndef ANALOG_THRESHOLD_UART_ECHO_ASSERT_SVH
`define ANALOG_THRESHOLD_UART_ECHO_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ATUE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ATUE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/atue_pkg.sv =====
// Package with types, constants and register codes of the analog threshold UART echo block.
package atue_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TICKS_PER_BIT  = 2'd0;
    localparam logic [1:0] CFG_LOW_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_HIGH_THRESHOLD = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] TICKS_PER_BIT_RESET  = 16'd8320;
    localparam logic [9:0]  LOW_THRESHOLD_RESET  = 10'd320;
    localparam logic [9:0]  HIGH_THRESHOLD_RESET = 10'd420;

    // Character codes for the echo path.
    localparam logic [7:0] CR_CODE = 8'd13;
    localparam logic [7:0] LF_CODE = 8'd10;

    // Transmit bit positions: start, data 1..8, stop.
    localparam logic [3:0] TX_START_BIT = 4'd0;
    localparam logic [3:0] TX_LAST_DATA = 4'd8;
    localparam logic [3:0] TX_STOP_BIT  = 4'd9;

    // Last data bit position of the receiver.
    localparam logic [3:0] RX_LAST_DATA = 4'd8;

    // Queue depth between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // One classified tick on its way from the front to the back.
    typedef struct packed {
        logic       below_low;
        logic       above_high;
        logic       send_valid;
        logic [7:0] send_byte;
    } tick_item_t;

    // One result of the back.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       tx_ready;
        logic       tx_level;
    } tick_result_t;

endpackage

// ===== src/atue_front.sv =====
// Front part: classifies each line sample against the thresholds and queues the tick.
module atue_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [9:0] line_sample, [17:10] send_byte, rest zero
    input  logic                 s_tuser,   // [0] send_valid
    input  logic [9:0]           low_threshold,
    input  logic [9:0]           high_threshold,
    output logic                 q_valid,
    output atue_pkg::tick_item_t q_item,
    input  logic                 q_pop
);

    localparam int PtrW = $clog2(atue_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(atue_pkg::QUEUE_DEPTH + 1);

    atue_pkg::tick_item_t entry_reg [atue_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]      count_reg, count_next;
    atue_pkg::tick_item_t new_item;
    logic                 push;
    logic [9:0]           line_sample;

    // Classify the incoming tick.
    assign line_sample          = s_tdata[9:0];
    assign new_item.below_low   = line_sample < low_threshold;
    assign new_item.above_high  = line_sample > high_threshold;
    assign new_item.send_valid  = s_tuser;
    assign new_item.send_byte   = s_tdata[17:10];

    // Queue handshake.
    assign s_tready = count_reg != CntW'(atue_pkg::QUEUE_DEPTH);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = count_reg != '0;
    assign q_item   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(atue_pkg::QUEUE_DEPTH - 1)) ? '0
                        : PtrW'(wr_ptr_reg + 1'b1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(atue_pkg::QUEUE_DEPTH - 1)) ? '0
                        : PtrW'(rd_ptr_reg + 1'b1);
        end
        if (push && !q_pop)
        begin
            count_next = CntW'(count_reg + 1'b1);
        end
        else if (q_pop && !push)
        begin
            count_next = CntW'(count_reg - 1'b1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== src/atue_back.sv =====
// Back part: runs the transmitter, the receiver and the echo slot, one tick per queued item.
module atue_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          ticks_per_bit,
    input  logic                 q_valid,
    input  atue_pkg::tick_item_t q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [0] tx_level, [1] tx_ready, [9:2] rx_byte, rest zero
    output logic                 m_tuser    // [0] rx_valid
);

    // Transmitter state.
    logic [7:0]  tx_shift_reg, tx_shift_next;
    logic [3:0]  tx_idx_reg, tx_idx_next;
    logic [16:0] tx_cnt_reg, tx_cnt_next;
    logic        tx_busy_reg, tx_busy_next;
    // Receiver state.
    logic        rx_busy_reg, rx_busy_next;
    logic [3:0]  rx_idx_reg, rx_idx_next;
    logic [15:0] rx_cnt_reg, rx_cnt_next;
    logic [7:0]  rx_shift_reg, rx_shift_next;
    // Echo slot.
    logic        echo_pend_reg, echo_pend_next;
    logic [7:0]  echo_byte_reg, echo_byte_next;
    // Output register.
    logic        out_valid_reg;
    atue_pkg::tick_result_t out_reg, out_next;

    logic [16:0] period;
    logic [16:0] dur;
    logic        tx_start;
    logic [16:0] tx_cnt_inc;
    logic [16:0] rx_cnt_inc;
    logic [3:0]  tx_idx_m1;
    logic [3:0]  rx_idx_inc;
    logic        tx_level;
    logic        rx_valid;
    logic [7:0]  rx_out;

    // A zero bit period acts as one tick; the stop level lasts one and a half periods.
    assign period = (ticks_per_bit == '0) ? 17'd1 : {1'b0, ticks_per_bit};

    // Take the next tick whenever the output register is free or being drained.
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    // One tick of the transmitter, then of the receiver.
    always_comb
    begin
        tx_shift_next  = tx_shift_reg;
        tx_idx_next    = tx_idx_reg;
        tx_cnt_next    = tx_cnt_reg;
        tx_busy_next   = tx_busy_reg;
        rx_busy_next   = rx_busy_reg;
        rx_idx_next    = rx_idx_reg;
        rx_cnt_next    = rx_cnt_reg;
        rx_shift_next  = rx_shift_reg;
        echo_pend_next = echo_pend_reg;
        echo_byte_next = echo_byte_reg;
        tx_level       = 1'b1;
        rx_valid       = 1'b0;
        rx_out         = '0;
        dur            = period;

        // Start a frame: the echo wins over the host byte.
        tx_start = !tx_busy_reg && (echo_pend_reg || q_item.send_valid);
        if (tx_start)
        begin
            tx_shift_next  = echo_pend_reg ? echo_byte_reg : q_item.send_byte;
            echo_pend_next = 1'b0;
            tx_busy_next   = 1'b1;
            tx_idx_next    = atue_pkg::TX_START_BIT;
            tx_cnt_next    = '0;
        end

        // Drive the current bit and advance the bit timer.
        tx_idx_m1  = 4'(tx_idx_next - 4'd1);
        tx_cnt_inc = 17'(tx_cnt_next + 17'd1);
        if (tx_busy_next)
        begin
            if (tx_idx_next == atue_pkg::TX_START_BIT)
            begin
                tx_level = 1'b0;
            end
            else if (tx_idx_next <= atue_pkg::TX_LAST_DATA)
            begin
                tx_level = tx_shift_next[tx_idx_m1[2:0]];
            end
            else
            begin
                dur = 17'(period + (period >> 1));
            end
            tx_cnt_next = tx_cnt_inc;
            if (tx_cnt_inc >= dur)
            begin
                tx_cnt_next = '0;
                if (tx_idx_next >= atue_pkg::TX_STOP_BIT)
                begin
                    tx_busy_next = 1'b0;
                    tx_idx_next  = '0;
                end
                else
                begin
                    tx_idx_next = 4'(tx_idx_next + 4'd1);
                end
            end
        end

        // Receiver: hunt for a start bit, then sample at whole-bit offsets.
        rx_cnt_inc = 17'({1'b0, rx_cnt_reg} + 17'd1);
        rx_idx_inc = 4'(rx_idx_reg + 4'd1);
        if (!rx_busy_reg)
        begin
            if (q_item.below_low)
            begin
                rx_busy_next  = 1'b1;
                rx_idx_next   = '0;
                rx_cnt_next   = '0;
                rx_shift_next = '0;
            end
        end
        else
        begin
            rx_cnt_next = rx_cnt_inc[15:0];
            if (rx_cnt_inc >= period)
            begin
                rx_cnt_next = '0;
                rx_idx_next = rx_idx_inc;
                if (rx_idx_inc <= atue_pkg::RX_LAST_DATA)
                begin
                    if (q_item.above_high)
                    begin
                        rx_shift_next[rx_idx_reg[2:0]] = 1'b1;
                    end
                end
                else
                begin
                    rx_valid       = 1'b1;
                    rx_out         = rx_shift_reg;
                    echo_byte_next = (rx_shift_reg == atue_pkg::CR_CODE) ? atue_pkg::LF_CODE
                                   : rx_shift_reg;
                    echo_pend_next = 1'b1;
                    rx_busy_next   = 1'b0;
                    rx_idx_next    = '0;
                end
            end
        end

        out_next.tx_level = tx_level;
        out_next.tx_ready = !tx_busy_next && !echo_pend_next;
        out_next.rx_valid = rx_valid;
        out_next.rx_byte  = rx_out;
    end

    // Engine state advances once per taken tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg  <= '0;
            tx_idx_reg    <= '0;
            tx_cnt_reg    <= '0;
            tx_busy_reg   <= 1'b0;
            rx_busy_reg   <= 1'b0;
            rx_idx_reg    <= '0;
            rx_cnt_reg    <= '0;
            rx_shift_reg  <= '0;
            echo_pend_reg <= 1'b0;
            echo_byte_reg <= '0;
        end
        else if (q_pop)
        begin
            tx_shift_reg  <= tx_shift_next;
            tx_idx_reg    <= tx_idx_next;
            tx_cnt_reg    <= tx_cnt_next;
            tx_busy_reg   <= tx_busy_next;
            rx_busy_reg   <= rx_busy_next;
            rx_idx_reg    <= rx_idx_next;
            rx_cnt_reg    <= rx_cnt_next;
            rx_shift_reg  <= rx_shift_next;
            echo_pend_reg <= echo_pend_next;
            echo_byte_reg <= echo_byte_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.rx_byte, out_reg.tx_ready, out_reg.tx_level};
    assign m_tuser  = out_reg.rx_valid;

endmodule

// ===== src/analog_threshold_uart_echo.sv =====
// Top level of the analog threshold UART echo block: configuration registers and the two parts.
//
//  Channel   Direction  Request contents
//  s_*       in         one clock tick: line_sample, send_byte (tdata), send_valid (tuser)
//  m_*       out        one result per tick: tx_level, tx_ready, rx_byte (tdata), rx_valid (tuser)
//  cfg_*     in         register write: cfg_index, cfg_data
//
// One request is taken per clock when neither side stalls; each result is registered first in
// the queue (classify and queue), then in the output register of the tick engine.
// The back engine applies one tick per cycle while m_* does not stall; its state update is the limiting loop.
// A two-entry queue sits between the parts, so a stall on m_* blocks s_* only once it fills.
// Reset clears all control state and loads the register reset values; no clearing pass.
module analog_threshold_uart_echo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [9:0] line_sample, [17:10] send_byte, rest zero
    input  logic        s_tuser,    // [0] send_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] tx_level, [1] tx_ready, [9:2] rx_byte, rest zero
    output logic        m_tuser,    // [0] rx_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] tpb_reg;
    logic [9:0]  low_thr_reg;
    logic [9:0]  high_thr_reg;
    logic                 q_valid;
    logic                 q_pop;
    atue_pkg::tick_item_t q_item;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpb_reg      <= atue_pkg::TICKS_PER_BIT_RESET;
            low_thr_reg  <= atue_pkg::LOW_THRESHOLD_RESET;
            high_thr_reg <= atue_pkg::HIGH_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                atue_pkg::CFG_TICKS_PER_BIT:  tpb_reg      <= cfg_data;
                atue_pkg::CFG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data[9:0];
                atue_pkg::CFG_HIGH_THRESHOLD: high_thr_reg <= cfg_data[9:0];
                default:                      ;
            endcase
        end
    end

    // Front: classify and queue.
    atue_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .low_threshold  (low_thr_reg),
        .high_threshold (high_thr_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    // Back: tick engine and output register.
    atue_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ticks_per_bit (tpb_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

// ===== src/atue_checker.sv =====
// Port-level checker for the analog threshold UART echo block, with its bind statement.
`include "analog_threshold_uart_echo_assert.svh"

module atue_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result holds its payload.
    `ATUE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // The received byte reads zero unless a byte completes on that tick.
    `ATUE_ASSERT_IMP(a_rx_byte_zero, m_tvalid && !m_tuser, m_tdata[9:2] == 8'd0)

    // An idle transmitter keeps the line high.
    `ATUE_ASSERT_IMP(a_ready_line_high, m_tvalid && m_tdata[1], m_tdata[0])

    // A completed byte queues an echo, so the transmitter is not ready on that tick.
    `ATUE_ASSERT_IMP(a_rx_blocks_ready, m_tvalid && m_tuser, !m_tdata[1])

    // Pad bits of the result stay zero.
    `ATUE_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[15:10] == 6'd0)

endmodule

bind analog_threshold_uart_echo atue_checker u_atue_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
